### hw/rtl/rgb_gray_average_pool_top_assert.svh
// Assertion macros shared by the pooling block's checkers.
`ifndef RGB_GRAY_AVERAGE_POOL_TOP_ASSERT_SVH
`define RGB_GRAY_AVERAGE_POOL_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RGP_ASSERT_IMM(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RGP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/rgp_pkg.sv
// Shared types, widths and constants of the RGB-to-gray pooling block.
package rgp_pkg;

	// Field widths
	localparam int PIX_W     = 8;
	localparam int FW_W      = 11;
	localparam int FH_W      = 12;
	localparam int WIN_W     = 4;
	localparam int STEP_W    = 4;
	localparam int LEVEL_W   = 4;
	localparam int OROW_W    = 11;
	localparam int OCOL_W    = 10;
	localparam int ROW_W     = 11;
	localparam int DIM_W     = 12;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 12;

	// Default sizes of the line store and the frame height limit
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_WINDOW = 8;
	localparam int MAX_HEIGHT     = 2048;

	// Register reset values
	localparam logic [FW_W-1:0]   FW_RESET   = 11'd640;
	localparam logic [FH_W-1:0]   FH_RESET   = 12'd480;
	localparam logic [WIN_W-1:0]  WIN_RESET  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_RESET = 4'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 4'd3;

	// Luma weights in 0.16 fixed point
	localparam logic [15:0] GRAY_R = 16'd19595;
	localparam logic [15:0] GRAY_G = 16'd38470;
	localparam logic [15:0] GRAY_B = 16'd7471;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic write;
		logic rd_issue;
		logic div_init;
		logic div_step;
		logic out_load;
	} rgp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic emit;
		logic rd_last;
		logic div_last;
	} rgp_sts_t;

endpackage

### hw/rtl/rgp_datapath.sv
// Datapath: gray conversion, banked line store, window summing and level division.
module rgp_datapath
	import rgp_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic [PIX_W-1:0]     red,
	input  logic [PIX_W-1:0]     green,
	input  logic [PIX_W-1:0]     blue,
	input  rgp_cmd_t             cmd,
	output rgp_sts_t             sts,
	output logic [LEVEL_W-1:0]   level,
	output logic [OROW_W-1:0]    out_row,
	output logic [OCOL_W-1:0]    out_col,
	output logic                 frame_last
);

	localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int WORDS  = (MAX_WIDTH + MAX_WINDOW - 1) / MAX_WINDOW;
	localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int ADDR_W = SLOT_W + WORD_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int SUM_W  = $clog2(255 * MAX_WINDOW * MAX_WINDOW + 1);
	localparam int REM_W  = SUM_W + 3;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WINDOW - 1);

	// Configuration registers
	logic [FW_W-1:0]   fw_q;
	logic [FH_W-1:0]   fh_q;
	logic [WIN_W-1:0]  win_cfg_q;
	logic [STEP_W-1:0] step_cfg_q;
	logic              cfg_hit;

	// Effective frame geometry
	logic [DIM_W-1:0]  w_eff;
	logic [DIM_W-1:0]  h_eff;
	logic [WIN_W-1:0]  win_eff;
	logic [WIN_W-1:0]  winm1;
	logic [STEP_W-1:0] st_eff;

	// Position of the next pixel
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] wbank_q;
	logic [WORD_W-1:0] wword_q;
	logic [SLOT_W-1:0] wslot_q;
	logic [STEP_W-1:0] cph_q;
	logic [STEP_W-1:0] rph_q;
	logic [COL_W-1:0]  ocol_q;
	logic [ROW_W-1:0]  orow_q;

	logic [COL_W-1:0]  nxt_col;
	logic [ROW_W-1:0]  nxt_row;
	logic [SLOT_W-1:0] nxt_bank;
	logic [WORD_W-1:0] nxt_word;
	logic [SLOT_W-1:0] nxt_slot;
	logic [STEP_W-1:0] nxt_cph;
	logic [STEP_W-1:0] nxt_rph;
	logic [COL_W-1:0]  nxt_ocol;
	logic [ROW_W-1:0]  nxt_orow;
	logic              col_wrap;
	logic              row_wrap;

	// Gray value and window read
	logic [23:0]       gray_sum;
	logic [PIX_W-1:0]  gray_s1;
	logic [SLOT_W-1:0] lbank_c;
	logic [WORD_W-1:0] lword_c;
	logic [SLOT_W-1:0] tslot_c;
	logic [SLOT_W-1:0] lbank_q;
	logic [WORD_W-1:0] lword_q;
	logic [SLOT_W-1:0] rslot_q;
	logic [WIN_W-1:0]  rcnt_q;
	logic              rd_s1;
	logic [PIX_W-1:0]  rdata_s1 [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] en_s1;
	logic [SUM_W-1:0]  row_sum;
	logic [SUM_W-1:0]  acc_q;

	// Emission info and division
	logic              emit_c;
	logic              last_c;
	logic [ROW_W-1:0]  erow_q;
	logic [COL_W-1:0]  ecol_q;
	logic              elast_q;
	logic [7:0]        win_sq;
	logic [15:0]       dsr16;
	logic [REM_W-1:0]  dsr_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  trial_div;
	logic [1:0]        dcnt_q;
	logic [LEVEL_W-1:0] q_q;

	// Output register
	logic [LEVEL_W-1:0] level_q;
	logic [OROW_W-1:0]  out_row_q;
	logic [OCOL_W-1:0]  out_col_q;
	logic               frame_last_q;

	// Clamp configuration to the supported ranges
	always_comb begin
		if (fw_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (int'(fw_q) > MAX_WIDTH) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = DIM_W'(fw_q);
		end
		if (fh_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (int'(fh_q) > MAX_HEIGHT) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = fh_q;
		end
		if (win_cfg_q == '0) begin
			win_eff = WIN_W'(1);
		end else if (int'(win_cfg_q) > MAX_WINDOW) begin
			win_eff = WIN_W'(MAX_WINDOW);
		end else begin
			win_eff = win_cfg_q;
		end
		winm1  = win_eff - 1'b1;
		st_eff = (step_cfg_q == '0) ? STEP_W'(1) : step_cfg_q;
	end

	assign cfg_hit = cfg_valid && (cfg_index == REG_FRAME_WIDTH ||
		cfg_index == REG_FRAME_HEIGHT || cfg_index == REG_WINDOW_SIZE ||
		cfg_index == REG_STEP_SIZE);

	// Emit when the pixel closes a window whose corner sits on the step grid
	always_comb begin
		emit_c = (DIM_W'(col_q) >= DIM_W'(winm1)) && (DIM_W'(row_q) >= DIM_W'(winm1)) &&
			(w_eff >= DIM_W'(win_eff)) && (h_eff >= DIM_W'(win_eff)) &&
			(cph_q == '0) && (rph_q == '0);
		last_c = ((DIM_W + 1)'(row_q) + (DIM_W + 1)'(st_eff) >= (DIM_W + 1)'(h_eff)) &&
			((DIM_W + 1)'(col_q) + (DIM_W + 1)'(st_eff) >= (DIM_W + 1)'(w_eff));
	end

	// Next raster position and grid phase
	always_comb begin
		nxt_col  = col_q;
		nxt_row  = row_q;
		nxt_bank = wbank_q;
		nxt_word = wword_q;
		nxt_slot = wslot_q;
		nxt_cph  = cph_q;
		nxt_rph  = rph_q;
		nxt_ocol = ocol_q;
		nxt_orow = orow_q;
		col_wrap = (DIM_W'(col_q) + 1'b1) >= w_eff;
		row_wrap = (DIM_W'(row_q) + 1'b1) >= h_eff;
		if (col_wrap) begin
			nxt_col  = '0;
			nxt_bank = '0;
			nxt_word = '0;
			nxt_cph  = '0;
			nxt_ocol = '0;
			nxt_row  = row_wrap ? '0 : row_q + 1'b1;
			if (row_wrap) begin
				nxt_slot = '0;
			end else begin
				nxt_slot = (wslot_q == SLOT_LAST) ? '0 : wslot_q + 1'b1;
			end
			if (nxt_row == '0 || DIM_W'(nxt_row) == DIM_W'(winm1)) begin
				nxt_rph  = '0;
				nxt_orow = '0;
			end else if (DIM_W'(nxt_row) > DIM_W'(winm1)) begin
				if (rph_q + 1'b1 == st_eff) begin
					nxt_rph  = '0;
					nxt_orow = orow_q + 1'b1;
				end else begin
					nxt_rph = rph_q + 1'b1;
				end
			end
		end else begin
			nxt_col = col_q + 1'b1;
			if (wbank_q == SLOT_LAST) begin
				nxt_bank = '0;
				nxt_word = wword_q + 1'b1;
			end else begin
				nxt_bank = wbank_q + 1'b1;
			end
			if (DIM_W'(nxt_col) == DIM_W'(winm1)) begin
				nxt_cph  = '0;
				nxt_ocol = '0;
			end else if (DIM_W'(nxt_col) > DIM_W'(winm1)) begin
				if (cph_q + 1'b1 == st_eff) begin
					nxt_cph  = '0;
					nxt_ocol = ocol_q + 1'b1;
				end else begin
					nxt_cph = cph_q + 1'b1;
				end
			end
		end
	end

	// Configuration writes and position counters; a write to a known register restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q       <= FW_RESET;
			fh_q       <= FH_RESET;
			win_cfg_q  <= WIN_RESET;
			step_cfg_q <= STEP_RESET;
			col_q      <= '0;
			row_q      <= '0;
			wbank_q    <= '0;
			wword_q    <= '0;
			wslot_q    <= '0;
			cph_q      <= '0;
			rph_q      <= '0;
			ocol_q     <= '0;
			orow_q     <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  fw_q       <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: fh_q       <= cfg_data[FH_W-1:0];
				REG_WINDOW_SIZE:  win_cfg_q  <= cfg_data[WIN_W-1:0];
				REG_STEP_SIZE:    step_cfg_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
			col_q   <= '0;
			row_q   <= '0;
			wbank_q <= '0;
			wword_q <= '0;
			wslot_q <= '0;
			cph_q   <= '0;
			rph_q   <= '0;
			ocol_q  <= '0;
			orow_q  <= '0;
		end else if (cmd.write) begin
			col_q   <= nxt_col;
			row_q   <= nxt_row;
			wbank_q <= nxt_bank;
			wword_q <= nxt_word;
			wslot_q <= nxt_slot;
			cph_q   <= nxt_cph;
			rph_q   <= nxt_rph;
			ocol_q  <= nxt_ocol;
			orow_q  <= nxt_orow;
		end
	end

	// Convert the pixel to gray on transfer
	assign gray_sum = 24'(GRAY_R) * 24'(red) + 24'(GRAY_G) * 24'(green) +
		24'(GRAY_B) * 24'(blue);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			gray_s1 <= gray_sum[23:16];
		end
	end

	// Window origin in the store: top slot, left bank and word
	always_comb begin
		if (int'(wslot_q) >= int'(winm1)) begin
			tslot_c = SLOT_W'(int'(wslot_q) - int'(winm1));
		end else begin
			tslot_c = SLOT_W'(int'(wslot_q) + MAX_WINDOW - int'(winm1));
		end
		if (int'(wbank_q) >= int'(winm1)) begin
			lbank_c = SLOT_W'(int'(wbank_q) - int'(winm1));
			lword_c = wword_q;
		end else begin
			lbank_c = SLOT_W'(int'(wbank_q) + MAX_WINDOW - int'(winm1));
			lword_c = wword_q - 1'b1;
		end
	end

	// Latch the window origin, emission info and divisor while storing the pixel
	assign win_sq = {4'b0, win_eff} * {4'b0, win_eff};
	assign dsr16  = {win_sq, 8'h00} - {8'h00, win_sq};

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			lbank_q <= lbank_c;
			lword_q <= lword_c;
			erow_q  <= orow_q;
			ecol_q  <= ocol_q;
			elast_q <= last_c;
			dsr_q   <= REM_W'(dsr16);
		end
	end

	// Walk the window rows, one row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rslot_q <= '0;
			rcnt_q  <= '0;
			rd_s1   <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd_issue;
			if (cmd.write) begin
				rslot_q <= tslot_c;
				rcnt_q  <= '0;
			end else if (cmd.rd_issue) begin
				rslot_q <= (rslot_q == SLOT_LAST) ? '0 : rslot_q + 1'b1;
				rcnt_q  <= rcnt_q + 1'b1;
			end
		end
	end

	// Column-interleaved line store: consecutive columns sit in separate banks
	for (genvar gk = 0; gk < MAX_WINDOW; gk++) begin : g_bank
		logic [PIX_W-1:0]  mem [DEPTH];
		logic [WORD_W-1:0] rword;
		logic              ren;

		always_comb begin
			if (gk >= int'(lbank_q)) begin
				ren   = (gk - int'(lbank_q)) < int'(win_eff);
				rword = lword_q;
			end else begin
				ren   = (gk + MAX_WINDOW - int'(lbank_q)) < int'(win_eff);
				rword = lword_q + 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.write && wbank_q == SLOT_W'(gk)) begin
				mem[{wslot_q, wword_q}] <= gray_s1;
			end
			rdata_s1[gk] <= mem[{rslot_q, rword}];
			en_s1[gk]    <= cmd.rd_issue && ren;
		end
	end

	// Sum the banks that fall inside the window
	always_comb begin
		row_sum = '0;
		for (int k = 0; k < MAX_WINDOW; k++) begin
			if (en_s1[k]) begin
				row_sum = row_sum + SUM_W'(rdata_s1[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			acc_q <= '0;
		end else if (rd_s1) begin
			acc_q <= acc_q + row_sum;
		end
	end

	// Restoring division of 8*sum by 255*window^2, one quotient bit per cycle
	assign trial_div = dsr_q << dcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_init) begin
			dcnt_q <= 2'd3;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= {acc_q, 3'b000};
			q_q   <= '0;
		end else if (cmd.div_step && rem_q >= trial_div) begin
			rem_q        <= rem_q - trial_div;
			q_q[dcnt_q]  <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			level_q      <= q_q;
			out_row_q    <= OROW_W'(erow_q);
			out_col_q    <= OCOL_W'(ecol_q);
			frame_last_q <= elast_q;
		end
	end

	assign sts.emit     = emit_c;
	assign sts.rd_last  = (rcnt_q == winm1);
	assign sts.div_last = (dcnt_q == 2'd0);

	assign level      = level_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign frame_last = frame_last_q;

endmodule

### hw/rtl/rgp_ctrl.sv
// Controller: sequences store, window read, division and output load per pixel.
module rgp_ctrl
	import rgp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  rgp_sts_t sts,
	output rgp_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_WRITE = 7'b0000010,
		S_READ  = 7'b0000100,
		S_DRAIN = 7'b0001000,
		S_DINIT = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d   = sts.emit ? S_READ : S_IDLE;
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				if (sts.rd_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hw/rtl/rgb_gray_average_pool_top.sv
// Top level of the RGB-to-gray average pooling block.
// Pixels enter in raster order, one per input transfer, and are stored as 8-bit gray in a
// column-interleaved line store of MAX_WINDOW rows. A pixel that closes no pooling window
// is taken and stored. A pixel that closes a window is taken and stored, after which
// the window is read one row per cycle across MAX_WINDOW banks, and the level is found by a
// 4-step restoring division, one quotient bit per cycle. The result sits in an output
// register, so the next pixel is taken while it waits. Any write to a known register restarts
// the frame at row 0, column 0; the line store needs no clearing pass after reset.
// cfg_ready is always high.
module rgb_gray_average_pool_top
	import rgp_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     red,
	input  logic [PIX_W-1:0]     green,
	input  logic [PIX_W-1:0]     blue,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [LEVEL_W-1:0]   level,
	output logic [OROW_W-1:0]    out_row,
	output logic [OCOL_W-1:0]    out_col,
	output logic                 frame_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	rgp_cmd_t cmd;
	rgp_sts_t sts;

	// Registers accept a write in any cycle
	assign cfg_ready = 1'b1;

	rgp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rgp_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_WINDOW (MAX_WINDOW)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.cmd        (cmd),
		.sts        (sts),
		.level      (level),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_last (frame_last)
	);

endmodule

### hw/rtl/rgp_checker.sv
// Port-level checker of the pooling block, bound to the top level.
`include "rgb_gray_average_pool_top_assert.svh"

module rgp_checker
	import rgp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [LEVEL_W-1:0] level,
	input logic [OROW_W-1:0]  out_row,
	input logic [OCOL_W-1:0]  out_col,
	input logic               frame_last
);

	// Level never exceeds the full-white value
	`RGP_ASSERT_IMM(a_level_range, out_valid, level <= 4'd8, "pooled level above 8")

	// One pixel at a time: input closes right after a transfer
	`RGP_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "in_ready high after transfer")

	// A result never rises directly after a pixel transfer
	`RGP_ASSERT_IMM(a_out_latency, $rose(out_valid), !$past(in_valid && in_ready), "result too early")

	// Stalled result holds
	`RGP_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(level) && $stable(out_row) && $stable(out_col) &&
		$stable(frame_last), "stalled result changed")

endmodule

bind rgb_gray_average_pool_top rgp_checker u_checker (.*);
